### hw/rtl/qkc_pkg.sv
// Shared types, phrase tables and helper functions for the query keyword classifier.
package qkc_pkg;

  // Window and storage sizes
  localparam int WIN_BYTES    = 11;
  localparam int RECENT_BYTES = 10;
  localparam int HEAD_BYTES   = 9;
  localparam int CNT_W        = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  typedef logic [7:0] char_t;
  typedef logic [WIN_BYTES-1:0][7:0]    win_t;     // byte 0 is the newest
  typedef logic [RECENT_BYTES-1:0][7:0] recent_t;  // byte 0 is the newest
  typedef logic [HEAD_BYTES-1:0][7:0]   lead_t;    // byte 0 is the first of the query
  typedef logic [WIN_BYTES-1:0][7:0]    phrase_t;  // last character in byte 0
  typedef logic [CNT_W-1:0]             plen_t;

  // Result codes
  typedef enum logic [2:0] {
    CAT_FACTUAL    = 3'd0,
    CAT_PROCEDURAL = 3'd1,
    CAT_PERSONAL   = 3'd2,
    CAT_TEMPORAL   = 3'd3,
    CAT_SEMANTIC   = 3'd4,
    CAT_EXACT      = 3'd5
  } category_t;

  // Control handed from the input stage to the scanner
  typedef struct packed {
    logic step;  // item leaves the input register this cycle
    logic has;   // item carries a byte
    logic last;  // item closes the query
  } scan_ctl_t;

  // Punctuation that marks an exact-match query
  localparam char_t CH_UNDERSCORE = 8'h5F;
  localparam char_t CH_DQUOTE     = 8'h22;
  localparam char_t CH_APOS       = 8'h27;
  localparam char_t CH_COLON      = 8'h3A;
  localparam char_t CH_DASH       = 8'h2D;
  localparam char_t CH_GT         = 8'h3E;

  // Leading phrases
  localparam int FACT_N = 7;
  localparam phrase_t FACT_PH [FACT_N] = '{
    "what is", "what are", "who is", "when did", "when was", "where is", "which "
  };
  localparam plen_t FACT_LEN [FACT_N] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd8, 4'd8, 4'd6};

  localparam int PROC_N = 4;
  localparam phrase_t PROC_PH [PROC_N] = '{"how to", "how do ", "steps for", "guide to"};
  localparam plen_t PROC_LEN [PROC_N] = '{4'd6, 4'd7, 4'd9, 4'd8};

  // Phrases found anywhere in the query
  localparam int PERS_N = 4;
  localparam phrase_t PERS_PH [PERS_N] = '{"my ", " i ", " me ", "last time i"};
  localparam plen_t PERS_LEN [PERS_N] = '{4'd3, 4'd3, 4'd4, 4'd11};

  localparam int TEMP_N = 6;
  localparam phrase_t TEMP_PH [TEMP_N] = '{
    "yesterday", "last week", "last month", "today", " ago", "202"
  };
  localparam plen_t TEMP_LEN [TEMP_N] = '{4'd9, 4'd9, 4'd10, 4'd5, 4'd4, 4'd3};

  // Fold A-Z to lower case, leave every other byte alone
  function automatic char_t fold_case(char_t c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // True when the newest n window bytes spell the phrase
  function automatic logic tail_match(win_t w, phrase_t p, plen_t n);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < WIN_BYTES; i++) begin
      if (i < int'(n) && w[i] != p[i]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  // True when the query opens with the phrase and holds at least n bytes
  function automatic logic head_match(lead_t l, logic [CNT_W-1:0] cnt, phrase_t p, plen_t n);
    logic hit;
    hit = (n <= cnt);
    for (int i = 0; i < HEAD_BYTES; i++) begin
      if (i < int'(n)) begin
        if (l[i] != p[int'(n) - 1 - i]) begin
          hit = 1'b0;
        end
      end
    end
    return hit;
  endfunction

endpackage

### hw/rtl/qkc_scan.sv
// Per-query scan state, phrase comparators and category decision.
module qkc_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qkc_pkg::scan_ctl_t   ctl,
  input  qkc_pkg::char_t       item_byte,
  output qkc_pkg::category_t   category
);

  qkc_pkg::lead_t              lead_r;
  qkc_pkg::recent_t            rec_r;
  logic [qkc_pkg::CNT_W-1:0]   cnt_r;
  logic                        pers_r;
  logic                        temp_r;
  logic                        exact_r;

  qkc_pkg::char_t              fold_c;
  qkc_pkg::win_t               win;
  qkc_pkg::lead_t              lead_view;
  logic [qkc_pkg::CNT_W-1:0]   cnt_nxt;
  logic                        pers_now;
  logic                        temp_now;
  logic                        exact_now;
  logic                        pers_nxt;
  logic                        temp_nxt;
  logic                        exact_nxt;
  logic                        fact_any;
  logic                        proc_any;
  logic                        head_room;

  assign fold_c    = qkc_pkg::fold_case(item_byte);
  assign win       = {rec_r, fold_c};
  assign head_room = (cnt_r < qkc_pkg::CNT_W'(qkc_pkg::HEAD_BYTES));

  // Match the contains-phrases on the window ending at the current byte
  always_comb begin
    pers_now = 1'b0;
    temp_now = 1'b0;
    for (int i = 0; i < qkc_pkg::PERS_N; i++) begin
      pers_now = pers_now | qkc_pkg::tail_match(win, qkc_pkg::PERS_PH[i], qkc_pkg::PERS_LEN[i]);
    end
    for (int i = 0; i < qkc_pkg::TEMP_N; i++) begin
      temp_now = temp_now | qkc_pkg::tail_match(win, qkc_pkg::TEMP_PH[i], qkc_pkg::TEMP_LEN[i]);
    end
  end

  // Quote, underscore or an operator pair marks an exact query
  assign exact_now = (fold_c == qkc_pkg::CH_UNDERSCORE) || (fold_c == qkc_pkg::CH_DQUOTE) ||
                     (fold_c == qkc_pkg::CH_APOS) ||
                     ((cnt_r != '0) &&
                      (((rec_r[0] == qkc_pkg::CH_COLON) && (fold_c == qkc_pkg::CH_COLON)) ||
                       ((rec_r[0] == qkc_pkg::CH_DASH) && (fold_c == qkc_pkg::CH_GT))));

  // State as it stands once the current byte is taken in
  always_comb begin
    lead_view = lead_r;
    cnt_nxt   = cnt_r;
    pers_nxt  = pers_r;
    temp_nxt  = temp_r;
    exact_nxt = exact_r;
    if (ctl.has) begin
      if (head_room) begin
        lead_view[cnt_r] = fold_c;
      end
      if (cnt_r != qkc_pkg::CNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      pers_nxt  = pers_r | pers_now;
      temp_nxt  = temp_r | temp_now;
      exact_nxt = exact_r | exact_now;
    end
  end

  // Compare the leading phrases
  always_comb begin
    fact_any = 1'b0;
    proc_any = 1'b0;
    for (int i = 0; i < qkc_pkg::FACT_N; i++) begin
      fact_any = fact_any |
                 qkc_pkg::head_match(lead_view, cnt_nxt, qkc_pkg::FACT_PH[i], qkc_pkg::FACT_LEN[i]);
    end
    for (int i = 0; i < qkc_pkg::PROC_N; i++) begin
      proc_any = proc_any |
                 qkc_pkg::head_match(lead_view, cnt_nxt, qkc_pkg::PROC_PH[i], qkc_pkg::PROC_LEN[i]);
    end
  end

  // Pick the category in priority order
  always_comb begin
    if (cnt_nxt == '0) begin
      category = qkc_pkg::CAT_SEMANTIC;
    end else if (fact_any) begin
      category = qkc_pkg::CAT_FACTUAL;
    end else if (proc_any) begin
      category = qkc_pkg::CAT_PROCEDURAL;
    end else if (pers_nxt) begin
      category = qkc_pkg::CAT_PERSONAL;
    end else if (temp_nxt) begin
      category = qkc_pkg::CAT_TEMPORAL;
    end else if (exact_nxt) begin
      category = qkc_pkg::CAT_EXACT;
    end else begin
      category = qkc_pkg::CAT_SEMANTIC;
    end
  end

  // Advance the scan state, clear it when a query closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r   <= '0;
      cnt_r   <= '0;
      pers_r  <= 1'b0;
      temp_r  <= 1'b0;
      exact_r <= 1'b0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        rec_r   <= '0;
        cnt_r   <= '0;
        pers_r  <= 1'b0;
        temp_r  <= 1'b0;
        exact_r <= 1'b0;
      end else if (ctl.has) begin
        rec_r   <= {rec_r[qkc_pkg::RECENT_BYTES-2:0], fold_c};
        cnt_r   <= cnt_nxt;
        pers_r  <= pers_nxt;
        temp_r  <= temp_nxt;
        exact_r <= exact_nxt;
      end
    end
  end

  // Record the leading bytes; only entries below the count are ever read
  always_ff @(posedge clk) begin
    if (ctl.step && ctl.has && head_room) begin
      lead_r[cnt_r] <= fold_c;
    end
  end

endmodule

### hw/rtl/query_keyword_classifier.sv
// Top level of the query keyword classifier: input register, scanner and result register.
// Path: an accepted byte is scanned from the input register; the category of a query is
//   loaded into the result register as its last request leaves, and shows on out_tdata.
// Throughput: one request per cycle, set by the single registered scan pass; a closing one may wait on the result slot.
// Reset: rst_n is synchronous and active low; it empties both registers and the scan state.
module query_keyword_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] query_byte
  input  logic [0:0] in_tuser,   // [0] has_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [2:0] category, [7:3] zero
);

  logic               in_v_r;
  qkc_pkg::char_t     in_byte_r;
  logic               in_has_r;
  logic               in_last_r;
  logic               out_v_r;
  logic [2:0]         out_cat_r;

  logic               out_free;
  logic               s1_go;
  logic               in_take;
  qkc_pkg::scan_ctl_t ctl;
  qkc_pkg::category_t scan_cat;

  // Handshake: a closing request waits only for the result slot
  assign out_free  = !out_v_r || out_tready;
  assign s1_go     = in_v_r && (!in_last_r || out_free);
  assign in_tready = !in_v_r || s1_go;
  assign in_take   = in_tvalid && in_tready;

  assign ctl.step = s1_go;
  assign ctl.has  = in_has_r;
  assign ctl.last = in_last_r;

  qkc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .item_byte (in_byte_r),
    .category  (scan_cat)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (s1_go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_has_r  <= in_tuser[0];
      in_last_r <= in_tlast;
    end
  end

  // Result register: load on a closing request, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && in_last_r) begin
      out_cat_r <= scan_cat;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, out_cat_r};

endmodule

### hw/rtl/qkc_checker.sv
// Port-level checks for the query keyword classifier, bound to the top level.
module qkc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic [0:0] in_tuser,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A fresh result must be preceded by an accepted closing request
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a closing request");

  // Input side never stalls while the result slot is free
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with a free result slot");

  // Fresh results carry a defined category and zero padding
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (out_tdata[7:3] == 5'd0) &&
                          (out_tdata[2:0] != 3'd6) && (out_tdata[2:0] != 3'd7))
    else $error("undefined category code");

endmodule

bind query_keyword_classifier qkc_checker u_qkc_checker (.*);
